>>> rtl/depth_point_sphere_fit_loss_top_defines.svh
// Assertion macros for the depth point sphere fit loss block.
// Taken in by the top level; the macros expect i_clk and i_rst_n in scope.
`ifndef DEPTH_POINT_SPHERE_FIT_LOSS_TOP_DEFINES_SVH
`define DEPTH_POINT_SPHERE_FIT_LOSS_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define DPSF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define DPSF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/dpsf_pkg.sv
// Shared types and constants of the depth point sphere fit loss block.
// Used by the divider, the square root unit, the top level and the testbench.
package dpsf_pkg;

    localparam logic [1:0] CMD_HDR = 2'd0;
    localparam logic [1:0] CMD_SPH = 2'd1;
    localparam logic [1:0] CMD_PIX = 2'd2;

    localparam logic [2:0] REG_FOCAL_X      = 3'd0;
    localparam logic [2:0] REG_FOCAL_Y      = 3'd1;
    localparam logic [2:0] REG_CENTER_U     = 3'd2;
    localparam logic [2:0] REG_CENTER_V     = 3'd3;
    localparam logic [2:0] REG_GRID_SIZE    = 3'd4;
    localparam logic [2:0] REG_SPHERE_COUNT = 3'd5;

    localparam logic [19:0] FOCAL_RST        = 20'd122880;
    localparam logic [15:0] CENTER_U_RST     = 16'd5120;
    localparam logic [15:0] CENTER_V_RST     = 16'd3840;
    localparam logic [7:0]  GRID_RST         = 8'd64;
    localparam logic [6:0]  SPHERE_COUNT_RST = 7'd41;

    localparam int DIV_NW = 57;
    localparam int DIV_DW = 48;

    localparam logic signed [25:0] Z_OFFSET    = 26'sd25600;
    localparam logic [32:0]        START_BOUND = 33'd3840000000;
    localparam logic [47:0]        SUM_MAX     = 48'hFFFF_FFFF_FFFF;
    localparam logic [22:0]        OUT_MAX     = 23'h7F_FFFF;
    localparam logic [41:0]        COORD_LIM   = 42'h100_0000_0000;
    localparam logic signed [42:0] DIFF_LIM    = 43'sd2147483647;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic [22:0]        radius;
    } t_sphere;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic        start;
        logic [63:0] radicand;
    } t_sqrt_req;

    typedef struct packed {
        logic        done;
        logic [32:0] root;
    } t_sqrt_rsp;

endpackage

>>> rtl/dpsf_if.sv
// Valid/ready channel interfaces for input items and result items.
// No dependencies beyond the payload widths of the block.
interface dpsf_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [15:0]        box_left;
    logic [15:0]        box_top;
    logic [15:0]        box_right;
    logic [15:0]        box_bottom;
    logic signed [23:0] mean_depth;
    logic signed [23:0] center_x;
    logic signed [23:0] center_y;
    logic signed [23:0] center_z;
    logic [22:0]        radius;
    logic [15:0]        depth_code;
    logic               last_of_batch;

    modport source (
        output valid, cmd, box_left, box_top, box_right, box_bottom, mean_depth,
               center_x, center_y, center_z, radius, depth_code, last_of_batch,
        input  ready
    );
    modport sink (
        input  valid, cmd, box_left, box_top, box_right, box_bottom, mean_depth,
               center_x, center_y, center_z, radius, depth_code, last_of_batch,
        output ready
    );
endinterface

interface dpsf_out_if;
    logic        valid;
    logic        ready;
    logic        pixel_valid;
    logic [5:0]  nearest_sphere;
    logic [22:0] surface_distance;
    logic [22:0] batch_loss;
    logic        last;

    modport source (
        output valid, pixel_valid, nearest_sphere, surface_distance, batch_loss, last,
        input  ready
    );
    modport sink (
        input  valid, pixel_valid, nearest_sphere, surface_distance, batch_loss, last,
        output ready
    );
endinterface

>>> rtl/dpsf_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on dpsf_pkg for the request and response structs.
module dpsf_div import dpsf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNTW = $clog2(DIV_NW);

    logic              r_busy;
    logic              r_done;
    logic [CNTW-1:0]   r_cnt;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_NW-1:0] r_q;
    logic [DIV_DW:0]   n_trial;
    logic              n_fits;

    assign n_trial = {r_rem, r_q[DIV_NW-1]};
    assign n_fits  = n_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(DIV_NW - 1);
                r_rem  <= '0;
                r_den  <= i_req.den;
                r_q    <= i_req.num;
            end else if (r_busy) begin
                if (n_fits) begin
                    r_rem <= DIV_DW'(n_trial - {1'b0, r_den});
                end else begin
                    r_rem <= n_trial[DIV_DW-1:0];
                end
                r_q <= {r_q[DIV_NW-2:0], n_fits};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNTW'(1);
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

>>> rtl/dpsf_sqrt.sv
// Digit-by-digit integer square root of a 64-bit value, rounded to nearest.
// Depends on dpsf_pkg for the request and response structs.
module dpsf_sqrt import dpsf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_sqrt_req i_req,
    output t_sqrt_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_x;
    logic [63:0] r_r;
    logic [63:0] r_bit;
    logic [64:0] n_sum;

    assign n_sum = {1'b0, r_r} + {1'b0, r_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd31;
                r_x    <= i_req.radicand;
                r_r    <= '0;
                r_bit  <= 64'h4000_0000_0000_0000;
            end else if (r_busy) begin
                if ({1'b0, r_x} >= n_sum) begin
                    r_x <= r_x - n_sum[63:0];
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end

    // A remainder above the root means the true root lies past the half step.
    assign o_rsp.done = r_done;
    assign o_rsp.root = (r_x > r_r) ? 33'(r_r) + 33'd1 : 33'(r_r);

endmodule

>>> rtl/depth_point_sphere_fit_loss_top.sv
// Top level of the depth point sphere fit loss block: sequencer, shared multiplier,
// sphere memory and configuration registers. Depends on dpsf_pkg, dpsf_if,
// dpsf_div, dpsf_sqrt and the assertion macro header.
//
//   channel   direction  handshake       carries
//   i_in      input      valid/ready     header, sphere load or depth pixel
//   o_out     output     valid/ready     one result per depth pixel
//   APB       input      psel/penable    six configuration registers
//
// Header, sphere load and unknown commands finish in the idle state. A zero-depth
// pixel skips the search. A valid pixel back-projects both axes with the shared
// multiplier and the divider, then per searched sphere forms the differences, sums
// their squares and waits on the square root; a batch's last pixel also divides for
// the loss. i_in.ready is low while a pixel is in work; a result waiting on o_out
// stalls only the next pixel's final state. Reset is synchronous and active low.
`include "depth_point_sphere_fit_loss_top_defines.svh"

module depth_point_sphere_fit_loss_top import dpsf_pkg::*; #(
    parameter int MAX_SPHERES = 64,
    parameter int MAX_GRID    = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dpsf_in_if.sink     i_in,
    dpsf_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW  = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int CW  = $clog2(MAX_SPHERES + 1);
    localparam int NLW = (CW > 7) ? CW : 7;
    localparam int PW  = $clog2(MAX_GRID);
    localparam int GW  = ($clog2(MAX_GRID + 1) > 8) ? $clog2(MAX_GRID + 1) : 8;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_MA    = 5'd1;
    localparam logic [4:0] S_MB    = 5'd2;
    localparam logic [4:0] S_MC    = 5'd3;
    localparam logic [4:0] S_MD    = 5'd4;
    localparam logic [4:0] S_ME    = 5'd5;
    localparam logic [4:0] S_MF    = 5'd6;
    localparam logic [4:0] S_DIVW  = 5'd7;
    localparam logic [4:0] S_RD    = 5'd8;
    localparam logic [4:0] S_DIF   = 5'd9;
    localparam logic [4:0] S_SQ0   = 5'd10;
    localparam logic [4:0] S_SQ1   = 5'd11;
    localparam logic [4:0] S_SQ2   = 5'd12;
    localparam logic [4:0] S_SQ3   = 5'd13;
    localparam logic [4:0] S_SQW   = 5'd14;
    localparam logic [4:0] S_FIN   = 5'd15;
    localparam logic [4:0] S_LA    = 5'd16;
    localparam logic [4:0] S_LB    = 5'd17;
    localparam logic [4:0] S_LDIVW = 5'd18;
    localparam logic [4:0] S_DONE  = 5'd19;

    function automatic logic signed [31:0] clamp_diff(input logic signed [42:0] v);
        if (v > DIFF_LIM) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -DIFF_LIM) begin
            return -32'sh7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    // Configuration and sample state
    logic [4:0]         r_state;
    logic [19:0]        r_focal_x, r_focal_y;
    logic [15:0]        r_center_u, r_center_v;
    logic [7:0]         r_grid;
    logic [6:0]         r_sphere_count;
    logic [CW-1:0]      r_load_idx;
    logic [15:0]        r_box_left, r_box_top, r_box_right, r_box_bottom;
    logic signed [23:0] r_centroid;
    logic [PW-1:0]      r_row, r_col;
    logic [47:0]        r_sum;
    logic [31:0]        r_vcount;
    logic [15:0]        r_samples;

    // Pixel work registers
    t_sphere            r_mem [MAX_SPHERES];
    t_sphere            r_rd;
    logic               r_last;
    logic               r_axis;
    logic               r_neg;
    logic signed [25:0] r_z;
    logic signed [33:0] r_acc;
    logic signed [57:0] r_num;
    logic signed [67:0] r_prod;
    logic signed [41:0] r_x, r_y;
    logic signed [31:0] r_dx, r_dy, r_dz;
    logic [63:0]        r_ssum;
    logic [32:0]        r_best;
    logic [IW-1:0]      r_best_id;
    logic               r_found;
    logic [IW-1:0]      r_j;
    logic [22:0]        r_loss;

    // Output register
    logic               r_ov;
    logic               r_o_pix;
    logic [5:0]         r_o_near;
    logic [22:0]        r_o_dist;
    logic [22:0]        r_o_loss;
    logic               r_o_last;

    logic               in_fire;
    logic               out_load;
    logic [GW-1:0]      g_eff;
    logic [NLW-1:0]     n_eff;
    logic [PW-1:0]      sel_pos;
    logic [15:0]        sel_lo, sel_hi, sel_c;
    logic [19:0]        sel_f;
    logic signed [16:0] span, lo_off;
    logic signed [33:0] mul_a, mul_b;
    logic [20:0]        code25;
    logic [15:0]        depth_off;
    logic signed [25:0] n_z;
    logic [56:0]        num_mag;
    logic [41:0]        n_qclamp;
    logic signed [41:0] n_coord;
    logic [32:0]        n_surf;
    logic [48:0]        n_sum_add;
    logic               last_sphere;
    logic [2:0]         reg_idx;
    t_div_req           div_req;
    t_div_rsp           div_rsp;
    t_sqrt_req          sqrt_req;
    t_sqrt_rsp          sqrt_rsp;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_load = (r_state == S_DONE) && (!r_ov || o_out.ready);
    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        g_eff = (r_grid == 8'd0) ? GW'(1) : GW'(r_grid);
        if (g_eff > GW'(MAX_GRID)) begin
            g_eff = GW'(MAX_GRID);
        end
    end

    assign n_eff = (NLW'(r_sphere_count) > NLW'(MAX_SPHERES)) ? NLW'(MAX_SPHERES)
                                                               : NLW'(r_sphere_count);
    assign last_sphere = (NLW'(r_j) + NLW'(1)) >= n_eff;

    // Per-axis operands of the back-projection
    assign sel_pos = r_axis ? r_row : r_col;
    assign sel_lo  = r_axis ? r_box_top : r_box_left;
    assign sel_hi  = r_axis ? r_box_bottom : r_box_right;
    assign sel_c   = r_axis ? r_center_v : r_center_u;
    assign sel_f   = r_axis ? r_focal_y : r_focal_x;
    assign span    = $signed({1'b0, sel_hi}) - $signed({1'b0, sel_lo});
    assign lo_off  = $signed({1'b0, sel_lo}) - $signed({1'b0, sel_c});

    // Shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MA: begin
                mul_a = $signed(34'(sel_pos));
                mul_b = 34'(span);
            end
            S_MB: begin
                mul_a = 34'(lo_off);
                mul_b = $signed(34'(g_eff));
            end
            S_MD: begin
                mul_a = r_acc;
                mul_b = 34'(r_z);
            end
            S_ME: begin
                mul_a = $signed(34'(g_eff));
                mul_b = (sel_f == 20'd0) ? 34'sd1 : $signed(34'(sel_f));
            end
            S_SQ0: begin
                mul_a = 34'(r_dx);
                mul_b = 34'(r_dx);
            end
            S_SQ1: begin
                mul_a = 34'(r_dy);
                mul_b = 34'(r_dy);
            end
            S_SQ2: begin
                mul_a = 34'(r_dz);
                mul_b = 34'(r_dz);
            end
            S_LA: begin
                mul_a = (r_samples == 16'd0) ? 34'sd1 : $signed(34'(r_samples));
                mul_b = $signed(34'(r_vcount) + 34'd1);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Depth in Q.8 mm: centroid plus 100 mm minus the scaled code, rounded half up.
    assign code25    = 21'(i_in.depth_code) * 21'd25;
    assign depth_off = 16'((code25 + 21'd16) >> 5);
    assign n_z       = 26'(r_centroid) + Z_OFFSET - $signed(26'(depth_off));

    assign num_mag  = r_num[57] ? 57'(-r_num) : 57'(r_num);
    assign n_qclamp = (div_rsp.quot > 57'(COORD_LIM)) ? COORD_LIM : div_rsp.quot[41:0];
    assign n_coord  = r_neg ? -$signed(n_qclamp) : $signed(n_qclamp);
    assign n_surf   = (sqrt_rsp.root > 33'(r_rd.radius)) ? sqrt_rsp.root - 33'(r_rd.radius)
                                                         : 33'(r_rd.radius) - sqrt_rsp.root;
    assign n_sum_add = {1'b0, r_sum} + 49'(r_best);

    always_comb begin
        div_req.start = (r_state == S_MF) || (r_state == S_LB);
        div_req.den   = r_prod[DIV_DW-1:0];
        if (r_state == S_LB) begin
            div_req.num = 57'(r_sum) + 57'(r_prod[47:1]);
        end else begin
            div_req.num = num_mag + 57'(r_prod[47:1]);
        end
    end

    assign sqrt_req.start    = (r_state == S_SQ3);
    assign sqrt_req.radicand = r_ssum + r_prod[63:0];

    dpsf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    dpsf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sqrt_req),
        .o_rsp   (sqrt_rsp)
    );

    // Sphere memory: one write port for loads, one registered read for the search.
    always_ff @(posedge i_clk) begin
        if (in_fire && (i_in.cmd == CMD_SPH) && (r_load_idx < CW'(MAX_SPHERES))) begin
            r_mem[r_load_idx[IW-1:0]] <= '{x: i_in.center_x, y: i_in.center_y,
                                           z: i_in.center_z, radius: i_in.radius};
        end
        if (r_state == S_RD) begin
            r_rd <= r_mem[r_j];
        end
    end

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_comb begin
        unique case (reg_idx)
            REG_FOCAL_X:      prdata = 32'(r_focal_x);
            REG_FOCAL_Y:      prdata = 32'(r_focal_y);
            REG_CENTER_U:     prdata = 32'(r_center_u);
            REG_CENTER_V:     prdata = 32'(r_center_v);
            REG_GRID_SIZE:    prdata = 32'(r_grid);
            REG_SPHERE_COUNT: prdata = 32'(r_sphere_count);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_focal_x      <= FOCAL_RST;
            r_focal_y      <= FOCAL_RST;
            r_center_u     <= CENTER_U_RST;
            r_center_v     <= CENTER_V_RST;
            r_grid         <= GRID_RST;
            r_sphere_count <= SPHERE_COUNT_RST;
            r_load_idx     <= '0;
            r_box_left     <= '0;
            r_box_top      <= '0;
            r_box_right    <= '0;
            r_box_bottom   <= '0;
            r_centroid     <= '0;
            r_row          <= '0;
            r_col          <= '0;
            r_sum          <= '0;
            r_vcount       <= '0;
            r_samples      <= '0;
            r_ov           <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                unique case (reg_idx)
                    REG_FOCAL_X:      r_focal_x      <= pwdata[19:0];
                    REG_FOCAL_Y:      r_focal_y      <= pwdata[19:0];
                    REG_CENTER_U:     r_center_u     <= pwdata[15:0];
                    REG_CENTER_V:     r_center_v     <= pwdata[15:0];
                    REG_GRID_SIZE:    r_grid         <= pwdata[7:0];
                    REG_SPHERE_COUNT: r_sphere_count <= pwdata[6:0];
                    default: begin
                    end
                endcase
            end

            if (r_ov && o_out.ready && !out_load) begin
                r_ov <= 1'b0;
            end

            r_prod <= mul_a * mul_b;

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        unique case (i_in.cmd)
                            CMD_HDR: begin
                                r_box_left   <= i_in.box_left;
                                r_box_top    <= i_in.box_top;
                                r_box_right  <= i_in.box_right;
                                r_box_bottom <= i_in.box_bottom;
                                r_centroid   <= i_in.mean_depth;
                                r_load_idx   <= '0;
                                r_row        <= '0;
                                r_col        <= '0;
                                if (r_samples != 16'hFFFF) begin
                                    r_samples <= r_samples + 16'd1;
                                end
                            end
                            CMD_SPH: begin
                                if (r_load_idx < CW'(MAX_SPHERES)) begin
                                    r_load_idx <= r_load_idx + CW'(1);
                                end
                            end
                            CMD_PIX: begin
                                r_last    <= i_in.last_of_batch;
                                r_z       <= n_z;
                                r_axis    <= 1'b0;
                                r_best    <= START_BOUND;
                                r_best_id <= '0;
                                r_found   <= 1'b0;
                                r_loss    <= '0;
                                if (i_in.depth_code != 16'd0) begin
                                    if (r_vcount != 32'hFFFF_FFFF) begin
                                        r_vcount <= r_vcount + 32'd1;
                                    end
                                    r_state <= S_MA;
                                end else begin
                                    r_state <= S_FIN;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_MA: r_state <= S_MB;
                S_MB: begin
                    r_acc   <= r_prod[33:0];
                    r_state <= S_MC;
                end
                S_MC: begin
                    r_acc   <= r_acc + r_prod[33:0];
                    r_state <= S_MD;
                end
                S_MD: r_state <= S_ME;
                S_ME: begin
                    r_num   <= {r_prod[53:0], 4'b0000};
                    r_state <= S_MF;
                end
                S_MF: begin
                    r_neg   <= r_num[57];
                    r_state <= S_DIVW;
                end
                S_DIVW: begin
                    if (div_rsp.done) begin
                        if (!r_axis) begin
                            r_x     <= n_coord;
                            r_axis  <= 1'b1;
                            r_state <= S_MA;
                        end else begin
                            r_y <= n_coord;
                            r_j <= '0;
                            r_state <= (n_eff == '0) ? S_FIN : S_RD;
                        end
                    end
                end
                S_RD: r_state <= S_DIF;
                S_DIF: begin
                    r_dx    <= clamp_diff(43'(r_x) - 43'(r_rd.x));
                    r_dy    <= clamp_diff(43'(r_y) - 43'(r_rd.y));
                    r_dz    <= clamp_diff(43'(r_z) - 43'(r_rd.z));
                    r_state <= S_SQ0;
                end
                S_SQ0: r_state <= S_SQ1;
                S_SQ1: begin
                    r_ssum  <= r_prod[63:0];
                    r_state <= S_SQ2;
                end
                S_SQ2: begin
                    r_ssum  <= r_ssum + r_prod[63:0];
                    r_state <= S_SQ3;
                end
                S_SQ3: r_state <= S_SQW;
                S_SQW: begin
                    if (sqrt_rsp.done) begin
                        // Strictly smaller only, so the first sphere keeps a tie.
                        if (n_surf < r_best) begin
                            r_best    <= n_surf;
                            r_best_id <= r_j;
                            r_found   <= 1'b1;
                        end
                        r_j     <= r_j + IW'(1);
                        r_state <= last_sphere ? S_FIN : S_RD;
                    end
                end
                S_FIN: begin
                    if (r_found) begin
                        r_sum <= (n_sum_add > 49'(SUM_MAX)) ? SUM_MAX : n_sum_add[47:0];
                    end else begin
                        r_best_id <= '0;
                    end
                    r_state <= r_last ? S_LA : S_DONE;
                end
                S_LA: r_state <= S_LB;
                S_LB: r_state <= S_LDIVW;
                S_LDIVW: begin
                    if (div_rsp.done) begin
                        r_loss  <= (div_rsp.quot > 57'(OUT_MAX)) ? OUT_MAX
                                                                 : div_rsp.quot[22:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_ov     <= 1'b1;
                        r_o_pix  <= r_found;
                        r_o_near <= 6'(r_best_id);
                        r_o_dist <= !r_found ? 23'd0
                                  : (r_best > 33'(OUT_MAX)) ? OUT_MAX : r_best[22:0];
                        r_o_loss <= r_loss;
                        r_o_last <= r_last;
                        if (r_last) begin
                            r_sum     <= '0;
                            r_vcount  <= '0;
                            r_samples <= '0;
                        end
                        if (GW'(r_col) + GW'(1) >= g_eff) begin
                            r_col <= '0;
                            if (GW'(r_row) + GW'(1) >= g_eff) begin
                                r_row <= '0;
                            end else begin
                                r_row <= r_row + PW'(1);
                            end
                        end else begin
                            r_col <= r_col + PW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid            = r_ov;
    assign o_out.pixel_valid      = r_o_pix;
    assign o_out.nearest_sphere   = r_o_near;
    assign o_out.surface_distance = r_o_dist;
    assign o_out.batch_loss       = r_o_loss;
    assign o_out.last             = r_o_last;

    `DPSF_ASSERT_IMP(a_div_done_waited, div_rsp.done,
        (r_state == S_DIVW) || (r_state == S_LDIVW), "divider finished outside a wait state")
    `DPSF_ASSERT_IMP(a_sphere_in_range, r_state == S_RD,
        NLW'(r_j) < n_eff, "sphere search ran past the searched count")
    `DPSF_ASSERT_NEXT(a_batch_clears, out_load && r_last,
        (r_sum == '0) && (r_vcount == '0) && (r_samples == '0), "batch totals not cleared")
    `DPSF_ASSERT_IMP(a_sqrt_done_waited, sqrt_rsp.done,
        r_state == S_SQW, "square root finished outside its wait state")

endmodule

>>> sim/tb_depth_point_sphere_fit_loss_top.sv
`timescale 1ns / 1ps
// Testbench of depth_point_sphere_fit_loss_top: directed table, then random samples.
// Depends on dpsf_pkg, the dpsf_in_if/dpsf_out_if interfaces and the block's RTL.
module tb_depth_point_sphere_fit_loss_top;
    import dpsf_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int         WATCHDOG_LIMIT = 20000;
    localparam int         ITEM_TARGET = 1550;

    typedef struct {
        logic [1:0]         cmd;
        logic [15:0]        left, top, right, bottom;
        logic signed [23:0] mdepth;
        logic signed [23:0] cx, cy, cz;
        logic [22:0]        rad;
        logic [15:0]        code;
        logic               lastb;
    } t_pix_item;

    typedef struct {
        logic        pvalid;
        logic [5:0]  sphere_id;
        logic [22:0] surf_dist;
        logic [22:0] loss;
        logic        lastr;
    } t_loss_result;

    typedef struct {
        t_pix_item    it;
        bit           typed;
        t_loss_result want;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dpsf_in_if  in_ch ();
    dpsf_out_if out_ch ();

    depth_point_sphere_fit_loss_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    // Mirror of the block's configuration and state.
    logic [19:0] m_fx, m_fy;
    logic [15:0] m_cu, m_cv;
    logic [7:0]  m_grid;
    logic [6:0]  m_count;
    longint      sph_x [64];
    longint      sph_y [64];
    longint      sph_z [64];
    longint      sph_r [64];
    int          load_idx;
    logic [15:0] bx_left, bx_top, bx_right, bx_bottom;
    longint      cdepth;
    int          prow, pcol;
    longint unsigned dsum;
    longint unsigned vcount;
    int          scount;

    t_loss_result expected_results[$];
    int  errors = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    bit  calm = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;
    int  idle_cycles = 0;

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
                 results_seen);
        errors++;
    endtask

    function automatic longint near_div(longint num, longint unsigned den);
        longint unsigned mag;
        longint          q;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        q = longint'((mag + den / 2) / den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint unsigned root_near(longint unsigned s);
        longint unsigned r, bitv, x;
        r = 0;
        bitv = 64'd1 << 62;
        x = s;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= r + bitv) begin
                x -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        if (s - r * r > r) r++;
        return r;
    endfunction

    function automatic longint back_project(int pos, longint lo, longint hi, longint c,
                                            longint g, longint f, longint z);
        longint          a;
        longint unsigned den;
        a = longint'(pos) * (hi - lo) + (lo - c) * g;
        den = longint'(g) * ((f == 0) ? 1 : f);
        return clip(near_div(a * z * 16, den), 64'sd1 << 40);
    endfunction

    // Advances the mirrored state by one item; returns 1 when the item yields a result.
    function automatic bit predict_loss(t_pix_item it, output t_loss_result r);
        int              g, n;
        longint          z, x, y, dx, dy, dz;
        longint unsigned best, s, c, d, samples, den;
        int              best_id;
        bit              found;
        r = '{default: '0};
        g = (m_grid == 0) ? 1 : ((m_grid > 128) ? 128 : int'(m_grid));
        case (it.cmd)
            CMD_HDR: begin
                bx_left = it.left; bx_top = it.top;
                bx_right = it.right; bx_bottom = it.bottom;
                cdepth = longint'(it.mdepth);
                load_idx = 0; prow = 0; pcol = 0;
                if (scount < 65535) scount++;
                return 1'b0;
            end
            CMD_SPH: begin
                if (load_idx < 64) begin
                    sph_x[load_idx] = longint'(it.cx);
                    sph_y[load_idx] = longint'(it.cy);
                    sph_z[load_idx] = longint'(it.cz);
                    sph_r[load_idx] = longint'(it.rad);
                    load_idx++;
                end
                return 1'b0;
            end
            CMD_PIX: begin
                best = 64'd3840000000;
                best_id = 0;
                found = 1'b0;
                if (it.code != 0) begin
                    z = cdepth + 25600 - longint'((25 * int'(it.code) + 16) >> 5);
                    x = back_project(pcol, bx_left, bx_right, m_cu, g, m_fx, z);
                    y = back_project(prow, bx_top, bx_bottom, m_cv, g, m_fy, z);
                    n = (m_count > 64) ? 64 : int'(m_count);
                    if (vcount < 64'hFFFF_FFFF) vcount++;
                    for (int j = 0; j < n; j++) begin
                        dx = clip(x - sph_x[j], 64'sd2147483647);
                        dy = clip(y - sph_y[j], 64'sd2147483647);
                        dz = clip(z - sph_z[j], 64'sd2147483647);
                        s = longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
                        c = root_near(s);
                        d = (c > sph_r[j]) ? c - sph_r[j] : sph_r[j] - c;
                        if (d < best) begin
                            best = d; best_id = j; found = 1'b1;
                        end
                    end
                    if (found) begin
                        r.pvalid = 1'b1;
                        r.sphere_id = best_id[5:0];
                        r.surf_dist = (best > 8388607) ? 23'h7F_FFFF : best[22:0];
                        dsum += best;
                        if (dsum > 64'hFFFF_FFFF_FFFF) dsum = 64'hFFFF_FFFF_FFFF;
                    end
                end
                if (it.lastb) begin
                    samples = (scount == 0) ? 1 : scount;
                    den = samples * (vcount + 1);
                    d = (dsum + den / 2) / den;
                    r.loss = (d > 8388607) ? 23'h7F_FFFF : d[22:0];
                    dsum = 0; vcount = 0; scount = 0;
                end
                r.lastr = it.lastb;
                pcol++;
                if (pcol >= g) begin
                    pcol = 0;
                    prow++;
                    if (prow >= g) prow = 0;
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0;
        case (idx)
            REG_FOCAL_X:      m_fx = val[19:0];
            REG_FOCAL_Y:      m_fy = val[19:0];
            REG_CENTER_U:     m_cu = val[15:0];
            REG_CENTER_V:     m_cv = val[15:0];
            REG_GRID_SIZE:    m_grid = val[7:0];
            REG_SPHERE_COUNT: m_count = val[6:0];
            default: ;
        endcase
    endtask

    task automatic write_config(logic [19:0] fx, logic [19:0] fy, logic [15:0] cu,
                                logic [15:0] cv, logic [7:0] g, logic [6:0] n);
        apb_write(REG_FOCAL_X, 32'(fx));
        apb_write(REG_FOCAL_Y, 32'(fy));
        apb_write(REG_CENTER_U, 32'(cu));
        apb_write(REG_CENTER_V, 32'(cv));
        apb_write(REG_GRID_SIZE, 32'(g));
        apb_write(REG_SPHERE_COUNT, 32'(n));
    endtask

    // Waits until every expected result has arrived, plus a short settling time.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic send_item(t_pix_item it, bit typed, t_loss_result want);
        t_loss_result r;
        if (!calm && $urandom_range(99) < 20) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.cmd           <= it.cmd;
        in_ch.box_left      <= it.left;
        in_ch.box_top       <= it.top;
        in_ch.box_right     <= it.right;
        in_ch.box_bottom    <= it.bottom;
        in_ch.mean_depth    <= it.mdepth;
        in_ch.center_x      <= it.cx;
        in_ch.center_y      <= it.cy;
        in_ch.center_z      <= it.cz;
        in_ch.radius        <= it.rad;
        in_ch.depth_code    <= it.code;
        in_ch.last_of_batch <= it.lastb;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        if (predict_loss(it, r)) expected_results.push_back(typed ? want : r);
        if (it.cmd != CMD_NONE) items_sent++;
        calm = (items_sent >= 400 && items_sent < 600);
    endtask

    function automatic t_pix_item noise_item(logic [1:0] cmd);
        t_pix_item it;
        it.cmd = cmd;
        it.left = 16'($urandom); it.top = 16'($urandom);
        it.right = 16'($urandom); it.bottom = 16'($urandom);
        it.mdepth = 24'($urandom); it.cx = 24'($urandom);
        it.cy = 24'($urandom); it.cz = 24'($urandom);
        it.rad = 23'($urandom); it.code = 16'($urandom); it.lastb = 1'($urandom);
        return it;
    endfunction

    function automatic t_pix_item mk(logic [1:0] cmd, logic [15:0] l, logic [15:0] t,
                                     logic [15:0] rt, logic [15:0] b, longint md,
                                     longint x, longint y, longint z, longint rad,
                                     logic [15:0] code, logic lastb);
        t_pix_item it;
        it.cmd = cmd; it.left = l; it.top = t; it.right = rt; it.bottom = b;
        it.mdepth = md[23:0]; it.cx = x[23:0]; it.cy = y[23:0]; it.cz = z[23:0];
        it.rad = rad[22:0]; it.code = code; it.lastb = lastb;
        return it;
    endfunction

    // Result channel: checking and the watchdog.
    always @(posedge i_clk) begin
        t_loss_result w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected item", 1, 0);
            end else begin
                w = expected_results.pop_front();
                if (out_ch.pixel_valid !== w.pvalid)
                    report_mismatch("pixel_valid", out_ch.pixel_valid, w.pvalid);
                if (out_ch.nearest_sphere !== w.sphere_id)
                    report_mismatch("nearest_sphere", out_ch.nearest_sphere, w.sphere_id);
                if (out_ch.surface_distance !== w.surf_dist)
                    report_mismatch("surface_distance", out_ch.surface_distance,
                                    w.surf_dist);
                if (out_ch.batch_loss !== w.loss)
                    report_mismatch("batch_loss", out_ch.batch_loss, w.loss);
                if (out_ch.last !== w.lastr)
                    report_mismatch("last", out_ch.last, w.lastr);
            end
        end
        if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready) || !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result channel ready pattern, with one long hold-off counted here.
    always @(posedge i_clk) begin
        if (!hold_done && results_seen >= 150) begin
            hold_done = 1'b1;
            hold_left = 3000;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (calm) begin
            out_ch.ready <= 1'b1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= 20);
        end
    end

    t_dir_row     rows[$];
    t_loss_result zero_res;
    t_loss_result dummy;

    initial begin
        t_pix_item   it;
        int          phase, budget, nsph, npix;
        logic [19:0] fx, fy;
        logic [15:0] cu, cv;
        logic [7:0]  g;
        logic [6:0]  n;

        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_ch.valid = 1'b0; in_ch.cmd = CMD_HDR;
        in_ch.box_left = '0; in_ch.box_top = '0; in_ch.box_right = '0; in_ch.box_bottom = '0;
        in_ch.mean_depth = '0; in_ch.center_x = '0; in_ch.center_y = '0; in_ch.center_z = '0;
        in_ch.radius = '0; in_ch.depth_code = '0; in_ch.last_of_batch = 1'b0;
        out_ch.ready = 1'b0;
        m_fx = FOCAL_RST; m_fy = FOCAL_RST; m_cu = CENTER_U_RST; m_cv = CENTER_V_RST;
        m_grid = GRID_RST; m_count = SPHERE_COUNT_RST;
        load_idx = 0; bx_left = '0; bx_top = '0; bx_right = '0; bx_bottom = '0;
        cdepth = 0; prow = 0; pcol = 0; dsum = 0; vcount = 0; scount = 0;
        zero_res = '{default: '0};
        dummy = zero_res;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: two spheres, a 2x2 grid so the raster wraps quickly.
        apb_write(REG_SPHERE_COUNT, 32'd2);
        apb_write(REG_GRID_SIZE, 32'd2);
        rows.push_back('{mk(CMD_PIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'd0, 1'b1), 1'b1,
                         '{1'b0, 6'd0, 23'd0, 23'd0, 1'b1}});
        rows.push_back('{mk(CMD_NONE, 1, 2, 3, 4, 5, 6, 7, 8, 9, 16'd10, 1'b1), 1'b0, dummy});
        rows.push_back('{mk(CMD_HDR, 0, 0, 1024, 1024, 128000, 0, 0, 0, 0, 0, 0), 1'b0, dummy});
        // Two identical spheres: the tie goes to the first.
        rows.push_back('{mk(CMD_SPH, 0, 0, 0, 0, 0, 0, 0, 140000, 0, 0, 0), 1'b0, dummy});
        rows.push_back('{mk(CMD_SPH, 0, 0, 0, 0, 0, 0, 0, 140000, 0, 0, 0), 1'b0, dummy});
        rows.push_back('{mk(CMD_PIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 0), 1'b0, dummy});
        rows.push_back('{mk(CMD_PIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'd1, 0), 1'b0, dummy});
        rows.push_back('{mk(CMD_PIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'd0, 0), 1'b1, zero_res});
        rows.push_back('{mk(CMD_PIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h8000, 0), 1'b0, dummy});
        rows.push_back('{mk(CMD_PIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h1234, 1), 1'b0, dummy});
        rows.push_back('{mk(CMD_HDR, 16'hFFFF, 16'hFFFF, 0, 0, -8388608, 0, 0, 0, 0, 0, 0),
                         1'b0, dummy});
        rows.push_back('{mk(CMD_SPH, 0, 0, 0, 0, 0, -8388608, -8388608, -8388608, 8388607,
                            0, 0), 1'b0, dummy});
        rows.push_back('{mk(CMD_SPH, 0, 0, 0, 0, 0, 8388607, 8388607, 8388607, 0, 0, 0),
                         1'b0, dummy});
        rows.push_back('{mk(CMD_PIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 0), 1'b0, dummy});
        rows.push_back('{mk(CMD_PIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'd1, 1), 1'b0, dummy});
        rows.push_back('{mk(CMD_HDR, 0, 0, 16'hFFFF, 16'hFFFF, 8388607, 0, 0, 0, 0, 0, 0),
                         1'b0, dummy});
        rows.push_back('{mk(CMD_SPH, 0, 0, 0, 0, 0, 100, -100, 50000, 8388607, 0, 0),
                         1'b0, dummy});
        rows.push_back('{mk(CMD_SPH, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0), 1'b0, dummy});
        rows.push_back('{mk(CMD_PIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 0), 1'b0, dummy});
        rows.push_back('{mk(CMD_PIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h00FF, 0), 1'b0, dummy});
        rows.push_back('{mk(CMD_PIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h7FFF, 1), 1'b0, dummy});
        foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].want);

        // Random part: each phase sets all registers, then runs samples.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            drain();
            case (phase)
                0: begin fx = 20'd1; fy = 20'd1; cu = 0; cv = 0; g = 8'd1; n = 7'd64; end
                1: begin fx = 20'hFFFFF; fy = 20'hFFFFF; cu = 16'hFFFF; cv = 16'hFFFF;
                         g = 8'd128; n = 7'd127; end
                2: begin fx = 20'd0; fy = 20'd0; cu = 5120; cv = 3840; g = 8'd0; n = 7'd0; end
                3: begin fx = 20'd122880; fy = 20'd60000; cu = 1000; cv = 2000;
                         g = 8'd255; n = 7'd1; end
                default: begin
                    fx = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(60000, 200000));
                    fy = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(60000, 200000));
                    cu = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6000));
                    cv = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6000));
                    g  = ($urandom_range(5) == 0) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(1, 12));
                    n  = 7'($urandom_range(1, 6));
                end
            endcase
            write_config(fx, fy, cu, cv, g, n);
            budget = (n >= 16) ? 12 : $urandom_range(40, 120);
            while (budget > 0 && items_sent < ITEM_TARGET) begin
                it = noise_item(CMD_HDR);
                if ($urandom_range(9) < 7) begin
                    it.left = 16'($urandom_range(0, 2000));
                    it.right = it.left + 16'($urandom_range(0, 3000));
                    it.top = 16'($urandom_range(0, 2000));
                    it.bottom = it.top + 16'($urandom_range(0, 3000));
                    it.mdepth = 24'($urandom_range(50000, 300000));
                end
                send_item(it, 1'b0, dummy);
                // The first sample fills the whole table and runs past its end.
                nsph = (phase == 0 && budget == 12) ? 67 : $urandom_range(0, 8);
                for (int k = 0; k < nsph; k++) begin
                    it = noise_item(CMD_SPH);
                    if ($urandom_range(9) < 8) begin
                        it.cx = 24'(int'($urandom_range(0, 200000)) - 100000);
                        it.cy = 24'(int'($urandom_range(0, 200000)) - 100000);
                        it.cz = 24'($urandom_range(0, 300000));
                        it.rad = 23'($urandom_range(0, 20000));
                    end
                    send_item(it, 1'b0, dummy);
                end
                npix = (n >= 16) ? $urandom_range(2, 4) : $urandom_range(4, 30);
                for (int k = 0; k < npix && budget > 0; k++) begin
                    if ($urandom_range(19) == 0) send_item(noise_item(CMD_NONE), 1'b0, dummy);
                    it = noise_item(CMD_PIX);
                    case ($urandom_range(19))
                        0, 1: it.code = 16'd0;
                        2:    it.code = 16'hFFFF;
                        3:    it.code = 16'd1;
                        default: ;
                    endcase
                    it.lastb = ((k == npix - 1) && $urandom_range(9) < 3) ||
                               ($urandom_range(29) == 0);
                    send_item(it, 1'b0, dummy);
                    budget--;
                end
            end
            phase++;
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/dpsf_pkg.sv
rtl/dpsf_if.sv
rtl/dpsf_div.sv
rtl/dpsf_sqrt.sv
rtl/depth_point_sphere_fit_loss_top.sv
sim/tb_depth_point_sphere_fit_loss_top.sv
